FILE: rtl/dmx_pkg.sv
// Package for the drive mixer: item types, stop causes and fixed-point constants.
// Used by every module of the block; depends on nothing.
package dmx_pkg;

  localparam int SPEED_SCALE_DEF      = 32;
  localparam int DEAD_ZONE_DEF        = 60;
  localparam int KEEPALIVE_PERIOD_DEF = 5;

  localparam int DUTY_W  = 13;
  localparam int SERVO_W = 10;
  localparam int LIMIT_W = 10;
  localparam int DIST_W  = 11;

  localparam logic [DUTY_W-1:0]  DUTY_MAX      = 13'h1FFF;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 10'd25;
  localparam logic [SERVO_W-1:0] SERVO_MAX     = 10'h3FF;
  localparam logic [11:0]        SERVO_BASE    = 12'd205;
  localparam logic [16:0]        SERVO_GAIN    = 17'd233;
  localparam logic [13:0]        WHEEL_FULL    = 14'd10000;
  localparam logic [15:0]        WHEEL_STEP    = 16'd222;
  localparam logic [7:0]         WHEEL_CUT_OFF = 8'd46;

  // Exact reciprocal multipliers for the operand ranges in use.
  localparam logic [26:0] DIV10K_MUL   = 27'd109951163;
  localparam int          DIV10K_SHIFT = 40;
  localparam logic [17:0] DIV100_MUL   = 18'd167773;
  localparam int          DIV100_SHIFT = 24;

  localparam logic OP_DRIVE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [2:0] {
    CAUSE_NONE,
    CAUSE_FRONT,
    CAUSE_BACK,
    CAUSE_LINK,
    CAUSE_KEEPALIVE
  } stop_cause_t;

  typedef struct packed {
    logic                     op;
    logic signed [8:0]        speed_cmd;
    logic signed [7:0]        steer_angle;
    logic [8:0]               servo_angle;
    logic signed [DIST_W-1:0] front_dist;
    logic signed [DIST_W-1:0] back_dist;
    logic                     link_ok;
  } in_item_t;

  typedef struct packed {
    logic              motor_write;
    logic              servo_write;
    logic              left_dir;
    logic              right_dir;
    stop_cause_t       stop_cause;
    logic [DUTY_W-1:0] speed;
    logic [13:0]       wheel_fac;
    logic              cut_left;
    logic [16:0]       servo_prod;
  } mix_t;

  typedef struct packed {
    logic               motor_write;
    logic [DUTY_W-1:0]  left_duty;
    logic [DUTY_W-1:0]  right_duty;
    logic               left_dir;
    logic               right_dir;
    logic               servo_write;
    logic [SERVO_W-1:0] servo_duty;
    stop_cause_t        stop_cause;
  } out_item_t;

endpackage

FILE: rtl/dmx_ctrl.sv
// Control stage of the drive mixer: holds the drive and safety state and decodes each item.
// Depends on dmx_pkg.
module dmx_ctrl import dmx_pkg::*; #(
  parameter int SPEED_SCALE      = SPEED_SCALE_DEF,
  parameter int DEAD_ZONE        = DEAD_ZONE_DEF,
  parameter int KEEPALIVE_PERIOD = KEEPALIVE_PERIOD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               item_valid,
  input  in_item_t           item,
  input  logic [LIMIT_W-1:0] distance_limit,
  output logic               mix_valid,
  output mix_t               mix
);

  localparam int SCALE_W = $clog2(SPEED_SCALE + 1);
  localparam int PROD_W  = 8 + SCALE_W;
  localparam int PH_W    = $clog2(KEEPALIVE_PERIOD);
  localparam logic signed [9:0] DZ_POS = 10'(DEAD_ZONE);
  localparam logic signed [9:0] DZ_NEG = -DZ_POS;

  logic                     fwd_r, fwd_nxt;
  logic                     rev_r, rev_nxt;
  logic signed [DIST_W-1:0] front_r, front_nxt;
  logic signed [DIST_W-1:0] back_r, back_nxt;
  logic signed [8:0]        alive_r, alive_nxt;
  logic [PH_W-1:0]          phase_r, phase_nxt;
  logic                     mix_valid_r;
  mix_t                     mix_r, mix_nxt;

  logic signed [11:0]   lim_s;
  logic                 lim_zero;
  logic signed [9:0]    s_ext;
  logic [8:0]           mag9;
  logic [7:0]           mag8;
  logic [PROD_W-1:0]    prod;
  logic [DUTY_W-1:0]    speed_sat;
  logic                 fwd_ok, rev_ok;
  logic [7:0]           steer_mag;
  logic [15:0]          cut_amount;
  logic                 front_stop, back_stop, link_stop, ka_stop, phase_one;

  always_comb begin
    lim_s    = signed'({2'b00, distance_limit});
    lim_zero = (distance_limit == '0);

    fwd_nxt   = fwd_r;
    rev_nxt   = rev_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    alive_nxt = alive_r;
    phase_nxt = phase_r;

    s_ext = 10'(item.speed_cmd);
    mag9  = item.speed_cmd[8] ? 9'(-item.speed_cmd) : 9'(item.speed_cmd);
    mag8  = mag9[8] ? 8'hFF : mag9[7:0];
    prod  = PROD_W'(mag8) * PROD_W'(SPEED_SCALE);
    speed_sat = ({13'd0, prod} > {PROD_W'(0), DUTY_MAX}) ? DUTY_MAX : DUTY_W'(prod);

    fwd_ok = (s_ext > DZ_POS) && (lim_zero || (12'(front_r) > lim_s));
    rev_ok = (s_ext < DZ_NEG) && (lim_zero || (12'(back_r) > lim_s));

    steer_mag  = item.steer_angle[7] ? 8'(-item.steer_angle) : 8'(item.steer_angle);
    cut_amount = 16'(steer_mag) * WHEEL_STEP;

    front_stop = 1'b0;
    back_stop  = 1'b0;
    link_stop  = 1'b0;
    ka_stop    = 1'b0;
    phase_one  = 1'b0;

    mix_nxt = '0;
    mix_nxt.servo_prod = 17'(item.servo_angle) * SERVO_GAIN;
    mix_nxt.cut_left   = item.steer_angle[7];
    mix_nxt.wheel_fac  = (steer_mag >= WHEEL_CUT_OFF) ? 14'd0 : WHEEL_FULL - cut_amount[13:0];
    mix_nxt.stop_cause = CAUSE_NONE;

    if (item.op == OP_DRIVE) begin
      if (alive_r < 9'sd255) begin
        alive_nxt = alive_r + 9'sd1;
      end
      if (fwd_ok) begin
        fwd_nxt = 1'b1;
        rev_nxt = 1'b0;
      end else if (rev_ok) begin
        fwd_nxt = 1'b0;
        rev_nxt = 1'b1;
      end
      mix_nxt.speed       = (fwd_ok || rev_ok) ? speed_sat : '0;
      mix_nxt.motor_write = 1'b1;
      mix_nxt.servo_write = 1'b1;
    end else begin
      front_nxt = item.front_dist;
      back_nxt  = item.back_dist;
      phase_nxt = (phase_r == PH_W'(KEEPALIVE_PERIOD - 1)) ? '0 : phase_r + PH_W'(1);
      phase_one = (phase_nxt == PH_W'(1));

      front_stop = !lim_zero && (12'(item.front_dist) < lim_s) && fwd_r && !rev_r;
      back_stop  = !lim_zero && (12'(item.back_dist) < lim_s) && !fwd_r && rev_r;
      link_stop  = !item.link_ok;
      ka_stop    = phase_one && (alive_r < 9'sd1);
      if (phase_one && !ka_stop) begin
        alive_nxt = -9'sd1;
      end

      priority if (front_stop) begin
        mix_nxt.stop_cause = CAUSE_FRONT;
      end else if (back_stop) begin
        mix_nxt.stop_cause = CAUSE_BACK;
      end else if (link_stop) begin
        mix_nxt.stop_cause = CAUSE_LINK;
      end else if (ka_stop) begin
        mix_nxt.stop_cause = CAUSE_KEEPALIVE;
      end else begin
        mix_nxt.stop_cause = CAUSE_NONE;
      end
      mix_nxt.speed       = '0;
      mix_nxt.motor_write = front_stop || back_stop || link_stop || ka_stop;
      mix_nxt.servo_write = 1'b0;
    end

    mix_nxt.left_dir  = fwd_nxt;
    mix_nxt.right_dir = rev_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r       <= 1'b0;
      rev_r       <= 1'b0;
      front_r     <= '0;
      back_r      <= '0;
      alive_r     <= -9'sd1;
      phase_r     <= '0;
      mix_valid_r <= 1'b0;
    end else if (en) begin
      mix_valid_r <= item_valid;
      if (item_valid) begin
        fwd_r   <= fwd_nxt;
        rev_r   <= rev_nxt;
        front_r <= front_nxt;
        back_r  <= back_nxt;
        alive_r <= alive_nxt;
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && item_valid) begin
      mix_r <= mix_nxt;
    end
  end

  assign mix_valid = mix_valid_r;
  assign mix       = mix_r;

endmodule

FILE: rtl/dmx_arith.sv
// Arithmetic stages of the drive mixer: wheel cut and servo scaling by reciprocal multiplication.
// Depends on dmx_pkg; fed by dmx_ctrl.
module dmx_arith import dmx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      mix_valid,
  input  mix_t      mix,
  output logic      res_valid,
  output out_item_t res
);

  typedef struct packed {
    logic              motor_write;
    logic              servo_write;
    logic              left_dir;
    logic              right_dir;
    stop_cause_t       stop_cause;
    logic [DUTY_W-1:0] speed;
    logic [26:0]       cut_prod;
    logic              cut_left;
    logic [10:0]       servo_ang;
  } prod_t;

  logic      prod_valid_r;
  prod_t     prod_r, prod_nxt;
  logic      res_valid_r;
  out_item_t res_r, res_nxt;

  logic [34:0] servo_mul;
  logic [53:0] cut_mul;
  logic [DUTY_W-1:0] cut_duty;
  logic [11:0] servo_sum;

  always_comb begin
    servo_mul = 35'(mix.servo_prod) * 35'(DIV100_MUL);
    prod_nxt.motor_write = mix.motor_write;
    prod_nxt.servo_write = mix.servo_write;
    prod_nxt.left_dir    = mix.left_dir;
    prod_nxt.right_dir   = mix.right_dir;
    prod_nxt.stop_cause  = mix.stop_cause;
    prod_nxt.speed       = mix.speed;
    prod_nxt.cut_prod    = 27'(mix.speed) * 27'(mix.wheel_fac);
    prod_nxt.cut_left    = mix.cut_left;
    prod_nxt.servo_ang   = servo_mul[DIV100_SHIFT +: 11];
  end

  always_comb begin
    cut_mul   = 54'(prod_r.cut_prod) * 54'(DIV10K_MUL);
    cut_duty  = cut_mul[DIV10K_SHIFT +: DUTY_W];
    servo_sum = SERVO_BASE + 12'(prod_r.servo_ang);

    res_nxt.motor_write = prod_r.motor_write;
    res_nxt.left_duty   = prod_r.cut_left ? cut_duty : prod_r.speed;
    res_nxt.right_duty  = prod_r.cut_left ? prod_r.speed : cut_duty;
    res_nxt.left_dir    = prod_r.left_dir;
    res_nxt.right_dir   = prod_r.right_dir;
    res_nxt.servo_write = prod_r.servo_write;
    res_nxt.stop_cause  = prod_r.stop_cause;
    if (!prod_r.servo_write) begin
      res_nxt.servo_duty = '0;
    end else if (servo_sum > 12'(SERVO_MAX)) begin
      res_nxt.servo_duty = SERVO_MAX;
    end else begin
      res_nxt.servo_duty = servo_sum[SERVO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else if (en) begin
      prod_valid_r <= mix_valid;
      res_valid_r  <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && mix_valid) begin
      prod_r <= prod_nxt;
    end
    if (en && prod_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

FILE: rtl/drive_mixer_with_safety_stop.sv
// Drive mixer with safety stop: a four-register pipeline that takes one item per cycle while
// the output is not held, and gives one result for each. The input register captures the item
// at the transfer, then come the control stage that updates the drive and safety state, the
// multiply stage and the reciprocal-divide stage, each registered in turn; the whole pipeline
// holds while a finished result waits on out_tready.
// Depends on dmx_pkg, dmx_ctrl and dmx_arith.
module drive_mixer_with_safety_stop import dmx_pkg::*; #(
  parameter int SPEED_SCALE      = SPEED_SCALE_DEF,
  parameter int DEAD_ZONE        = DEAD_ZONE_DEF,
  parameter int KEEPALIVE_PERIOD = KEEPALIVE_PERIOD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // speed_cmd, steer_angle, servo_angle, front_dist, back_dist, link_ok
  input  logic [55:0]        in_tdata,
  // op
  input  logic               in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  // motor_write, left_duty, right_duty, left_dir, right_dir, servo_write, servo_duty,
  // stop_cause
  output logic [47:0]        out_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  logic               en;
  logic               in_valid_r;
  in_item_t           item_r, item_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic               mix_valid;
  mix_t               mix;
  logic               res_valid;
  out_item_t          res;

  assign en        = !res_valid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_comb begin
    item_nxt.op          = in_tuser;
    item_nxt.speed_cmd   = signed'(in_tdata[8:0]);
    item_nxt.steer_angle = signed'(in_tdata[16:9]);
    item_nxt.servo_angle = in_tdata[25:17];
    item_nxt.front_dist  = signed'(in_tdata[36:26]);
    item_nxt.back_dist   = signed'(in_tdata[47:37]);
    item_nxt.link_ok     = in_tdata[48];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      limit_r    <= LIMIT_RESET;
    end else begin
      if (en) begin
        in_valid_r <= in_tvalid;
      end
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_tvalid) begin
      item_r <= item_nxt;
    end
  end

  dmx_ctrl #(
    .SPEED_SCALE      (SPEED_SCALE),
    .DEAD_ZONE        (DEAD_ZONE),
    .KEEPALIVE_PERIOD (KEEPALIVE_PERIOD)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .item_valid     (in_valid_r),
    .item           (item_r),
    .distance_limit (limit_r),
    .mix_valid      (mix_valid),
    .mix            (mix)
  );

  dmx_arith u_arith (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .mix_valid (mix_valid),
    .mix       (mix),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {5'd0, res.stop_cause, res.servo_duty, res.servo_write, res.right_dir,
                       res.left_dir, res.right_duty, res.left_duty, res.motor_write};

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for drive_mixer_with_safety_stop: directed and random drive commands and
// safety ticks, with an in-order prediction of every result and random stalls on both sides.
// Depends on dmx_pkg and the block's RTL.
module tb;
  import dmx_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 10;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [55:0]        in_tdata;
  logic               in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [47:0]        out_tdata;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;

  drive_mixer_with_safety_stop dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Predicted drive and safety state.
  bit        drv_fwd;
  bit        drv_rev;
  int        seen_front;
  int        seen_back;
  int        cmd_count;
  int        window_phase;
  int        stop_limit;

  out_item_t expected_q[$];
  int        fail_count;
  int        burst_left;
  int        idle_cycles;
  int        rx_mode;
  int        rx_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int inner_wheel(int spd, int cut);
    longint v;
    v = longint'(spd) * 10000 - longint'(spd) * cut * 222;
    if (v <= 0) return 0;
    return int'(v / 10000);
  endfunction

  function automatic out_item_t mix_and_guard(in_item_t it);
    out_item_t   r;
    int          sv;
    int          steer;
    int          mag;
    int          spd;
    int          lft;
    int          rgt;
    int          sd;
    bit          stop;
    stop_cause_t cause;
    r = '0;
    if (it.op == OP_DRIVE) begin
      sv = int'(it.speed_cmd);
      steer = int'(it.steer_angle);
      mag = (sv < 0) ? -sv : sv;
      if (mag > 255) mag = 255;
      if (cmd_count < 255) cmd_count++;
      spd = 0;
      if (sv > DEAD_ZONE_DEF) begin
        if (stop_limit == 0 || seen_front > stop_limit) begin
          spd = mag * SPEED_SCALE_DEF;
          drv_fwd = 1'b1;
          drv_rev = 1'b0;
        end
      end else if (sv < -DEAD_ZONE_DEF) begin
        if (stop_limit == 0 || seen_back > stop_limit) begin
          spd = mag * SPEED_SCALE_DEF;
          drv_fwd = 1'b0;
          drv_rev = 1'b1;
        end
      end
      if (spd > int'(DUTY_MAX)) spd = int'(DUTY_MAX);
      lft = spd;
      rgt = spd;
      if (steer > 0) rgt = inner_wheel(spd, steer);
      else if (steer < 0) lft = inner_wheel(spd, -steer);
      sd = 205 + int'(it.servo_angle) * 233 / 100;
      if (sd > int'(SERVO_MAX)) sd = int'(SERVO_MAX);
      r.motor_write = 1'b1;
      r.left_duty   = DUTY_W'(lft);
      r.right_duty  = DUTY_W'(rgt);
      r.servo_write = 1'b1;
      r.servo_duty  = SERVO_W'(sd);
      r.stop_cause  = CAUSE_NONE;
    end else begin
      seen_front = int'(it.front_dist);
      seen_back = int'(it.back_dist);
      window_phase = (window_phase + 1) % KEEPALIVE_PERIOD_DEF;
      stop = 1'b0;
      cause = CAUSE_NONE;
      if (stop_limit != 0) begin
        if (seen_front < stop_limit && drv_fwd && !drv_rev) begin
          stop = 1'b1;
          if (cause == CAUSE_NONE) cause = CAUSE_FRONT;
        end
        if (seen_back < stop_limit && !drv_fwd && drv_rev) begin
          stop = 1'b1;
          if (cause == CAUSE_NONE) cause = CAUSE_BACK;
        end
      end
      if (!it.link_ok) begin
        stop = 1'b1;
        if (cause == CAUSE_NONE) cause = CAUSE_LINK;
      end
      if (window_phase == 1) begin
        if (cmd_count < 1) begin
          stop = 1'b1;
          if (cause == CAUSE_NONE) cause = CAUSE_KEEPALIVE;
        end else begin
          cmd_count = -1;
        end
      end
      r.motor_write = stop;
      r.stop_cause  = cause;
    end
    r.left_dir  = drv_fwd;
    r.right_dir = drv_rev;
    return r;
  endfunction

  // Fields that an operation ignores are filled with random values.
  function automatic in_item_t drive_cmd(int spd, int steer, int servo);
    in_item_t it;
    it.op          = OP_DRIVE;
    it.speed_cmd   = 9'(spd);
    it.steer_angle = 8'(steer);
    it.servo_angle = 9'(servo);
    it.front_dist  = 11'($urandom);
    it.back_dist   = 11'($urandom);
    it.link_ok     = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t safety_tick(int front, int back, bit link);
    in_item_t it;
    it.op          = OP_TICK;
    it.speed_cmd   = 9'($urandom);
    it.steer_angle = 8'($urandom);
    it.servo_angle = 9'($urandom);
    it.front_dist  = 11'(front);
    it.back_dist   = 11'(back);
    it.link_ok     = link;
    return it;
  endfunction

  function automatic int rand_range(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int rand_dist();
    int pick;
    int d;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      d = rand_range(stop_limit, 1023);
    end else if (pick < 85) begin
      d = stop_limit + rand_range(-3, 3);
    end else if (pick < 92) begin
      d = -100;
    end else begin
      d = rand_range(-1024, 1023);
    end
    if (d > 1023) d = 1023;
    if (d < -1024) d = -1024;
    return d;
  endfunction

  function automatic in_item_t rand_item(int tick_pct);
    int pick;
    int spd;
    int steer;
    int servo;
    if (int'($urandom_range(0, 99)) < tick_pct)
      return safety_tick(rand_dist(), rand_dist(), $urandom_range(0, 19) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 25) spd = rand_range(-60, 60);
    else if (pick < 35) spd = rand_range(58, 63) * (($urandom_range(0, 1) != 0) ? 1 : -1);
    else if (pick < 40) spd = ($urandom_range(0, 1) != 0) ? 255 : -256;
    else spd = rand_range(-256, 255);
    pick = $urandom_range(0, 99);
    if (pick < 10) steer = 0;
    else if (pick < 80) steer = rand_range(-90, 90);
    else steer = rand_range(-128, 127);
    servo = ($urandom_range(0, 6) != 0) ? rand_range(0, 351) : rand_range(0, 511);
    return drive_cmd(spd, steer, servo);
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {7'b0, it.link_ok, it.back_dist, it.front_dist, it.servo_angle,
                  it.steer_angle, it.speed_cmd};
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(mix_and_guard(it));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input int value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= LIMIT_W'(value);
    do @(posedge clk); while (!cfg_ready);
    stop_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_dead_zone_and_scale();
    send_item(safety_tick(1023, 1023, 1'b1));
    send_item(drive_cmd(60, 0, 0));
    send_item(drive_cmd(61, 0, 351));
    send_item(drive_cmd(-60, 0, 100));
    send_item(drive_cmd(-61, 0, 200));
    send_item(drive_cmd(-256, 0, 511));
    send_item(drive_cmd(255, 0, 352));
  endtask

  task automatic test_steering();
    send_item(drive_cmd(200, 1, 0));
    send_item(drive_cmd(200, -1, 10));
    send_item(drive_cmd(255, 45, 90));
    send_item(drive_cmd(255, -46, 180));
    send_item(drive_cmd(100, 90, 270));
    send_item(drive_cmd(-200, -128, 300));
    send_item(drive_cmd(200, 127, 45));
  endtask

  task automatic test_obstacle_stop();
    send_item(safety_tick(25, 1023, 1'b1));
    send_item(drive_cmd(150, 0, 0));
    send_item(safety_tick(24, 24, 1'b1));
    send_item(drive_cmd(-150, 0, 0));
    send_item(safety_tick(26, 26, 1'b0));
    send_item(drive_cmd(-150, 10, 0));
    send_item(safety_tick(26, -100, 1'b0));
  endtask

  task automatic test_limit_extremes();
    write_limit(0);
    send_item(safety_tick(-100, -100, 1'b1));
    send_item(drive_cmd(100, 0, 0));
    write_limit(1023);
    send_item(safety_tick(1023, 1023, 1'b1));
    send_item(drive_cmd(100, 0, 0));
  endtask

  // Each phase runs under its own obstacle limit and tick density; the phase without
  // ticks lets the command count reach its ceiling.
  task automatic test_random_traffic();
    int limits[6];
    int tick_pcts[6];
    int counts[6];
    limits    = '{25, 0, 1023, 1, 25, 0};
    tick_pcts = '{30, 30, 30, 60, 0, 75};
    counts    = '{170, 150, 120, 150, 270, 190};
    limits[5] = $urandom_range(0, 1023);
    for (int p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      repeat (counts[p]) send_item(rand_item(tick_pcts[p]));
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with no expectation pending: %h", out_tdata);
        fail_count++;
      end else begin
        exp_r = expected_q.pop_front();
        check_field("motor_write", int'(exp_r.motor_write), int'(out_tdata[0]));
        check_field("left_duty", int'(exp_r.left_duty), int'(out_tdata[13:1]));
        check_field("right_duty", int'(exp_r.right_duty), int'(out_tdata[26:14]));
        check_field("left_dir", int'(exp_r.left_dir), int'(out_tdata[27]));
        check_field("right_dir", int'(exp_r.right_dir), int'(out_tdata[28]));
        check_field("servo_write", int'(exp_r.servo_write), int'(out_tdata[29]));
        check_field("servo_duty", int'(exp_r.servo_duty), int'(out_tdata[39:30]));
        check_field("stop_cause", int'(exp_r.stop_cause), int'(out_tdata[42:40]));
      end
    end
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_tready <= ((rx_left % 5) < 2);
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    out_tready   = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    idle_cycles  = 0;
    fail_count   = 0;
    burst_left   = 0;
    rx_mode      = 0;
    rx_left      = 0;
    drv_fwd      = 1'b0;
    drv_rev      = 1'b0;
    seen_front   = 0;
    seen_back    = 0;
    cmd_count    = -1;
    window_phase = 0;
    stop_limit   = int'(LIMIT_RESET);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_dead_zone_and_scale();
    test_steering();
    test_obstacle_stop();
    test_limit_extremes();
    test_random_traffic();

    wait_idle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: drive_mixer_with_safety_stop.f
rtl/dmx_pkg.sv
rtl/dmx_ctrl.sv
rtl/dmx_arith.sv
rtl/drive_mixer_with_safety_stop.sv
bench/tb.sv
